FILE: sv/bbe_pkg.sv
// bbe_pkg: shared sizes, register indexes and reset values for the edge-aware 3x3 box blur
// used by box_blur_3x3_edge_aware and bbe_div
// no dependencies
package bbe_pkg;

   // frame geometry limits
   localparam int MAX_WIDTH   = 1024;
   localparam int MAX_HEIGHT  = 4096;
   localparam int STORE_DEPTH = 3 * MAX_WIDTH;

   // field and counter widths
   localparam int COL_W    = 10;
   localparam int ROW_W    = 12;
   localparam int FW_W     = 11;
   localparam int FH_W     = 13;
   localparam int SLOT_W   = 2;
   localparam int ADDR_W   = 12;
   localparam int PIX_CH_W = 8;
   localparam int SUM_W    = 12;
   localparam int CNT_W    = 4;

   // rounding divider: (2*sum + count) / (2*count)
   localparam int DIV_NUM_W  = 13;
   localparam int DIV_DEN_W  = 5;
   localparam int DIV_STEP_W = 4;
   localparam logic [DIV_STEP_W-1:0] DIV_LAST_STEP = DIV_STEP_W'(DIV_NUM_W - 1);

   // configuration port
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 13;
   localparam logic [CSR_INDEX_W-1:0] CSR_FRAME_WIDTH  = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_FRAME_HEIGHT = 1'b1;

   // register reset values
   localparam logic [FW_W-1:0] FW_RESET = 11'd640;
   localparam logic [FH_W-1:0] FH_RESET = 13'd480;

endpackage

FILE: sv/bbe_div.sv
// bbe_div: one-bit-per-cycle restoring divider for the rounded channel mean
// depends on bbe_pkg for operand widths
module bbe_div import bbe_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [DIV_NUM_W-1:0] num,
   input  logic [DIV_DEN_W-1:0] den,
   output logic                 done,
   output logic [PIX_CH_W-1:0]  quot
);

   logic                  busy_ff;
   logic                  done_ff;
   logic [DIV_STEP_W-1:0] step_ff;
   logic [DIV_NUM_W-1:0]  num_ff;
   logic [DIV_DEN_W-1:0]  den_ff;
   logic [DIV_DEN_W-1:0]  rem_ff;
   logic [PIX_CH_W-1:0]   quot_ff;

   logic [DIV_DEN_W:0]    rem_sh;
   logic                  fits;
   logic [DIV_DEN_W:0]    rem_in;

   // one quotient bit per cycle
   always_comb begin
      rem_sh = {rem_ff, num_ff[DIV_NUM_W-1]};
      fits   = rem_sh >= {1'b0, den_ff};
      rem_in = fits ? (rem_sh - {1'b0, den_ff}) : rem_sh;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            step_ff <= DIV_LAST_STEP;
         end else if (busy_ff) begin
            step_ff <= step_ff - 1'b1;
            if (step_ff == '0) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // datapath, no reset needed
   always_ff @(posedge clock) begin
      if (start) begin
         num_ff  <= num;
         den_ff  <= den;
         rem_ff  <= '0;
         quot_ff <= '0;
      end else if (busy_ff) begin
         num_ff  <= {num_ff[DIV_NUM_W-2:0], 1'b0};
         rem_ff  <= rem_in[DIV_DEN_W-1:0];
         quot_ff <= {quot_ff[PIX_CH_W-2:0], fits};
      end
   end

   assign done = done_ff;
   assign quot = quot_ff;

endmodule

FILE: sv/box_blur_3x3_edge_aware.sv
// box_blur_3x3_edge_aware: streaming 3x3 box blur, mean over the in-bounds neighborhood
// sequence per result: count line store reads (count = 1..9), one per cycle,
// then drain, divider kick, 13 divider steps, done and load; reads go through the single read port
// input: a pixel beat that completes no result leaves the block idle for the next beat; one that
// completes results holds the input until the last of them is loaded (at most four results)
// reset: row/column counters cleared, frame size 640 x 480, line store contents left as is
// depends on bbe_pkg and bbe_div
module box_blur_3x3_edge_aware import bbe_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   // pixel input
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [PIX_CH_W-1:0]    req_red_in,
   input  logic [PIX_CH_W-1:0]    req_green_in,
   input  logic [PIX_CH_W-1:0]    req_blue_in,
   // blurred output
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [ROW_W-1:0]       rsp_out_row,
   output logic [COL_W-1:0]       rsp_out_col,
   output logic [PIX_CH_W-1:0]    rsp_red_out,
   output logic [PIX_CH_W-1:0]    rsp_green_out,
   output logic [PIX_CH_W-1:0]    rsp_blue_out,
   output logic                   rsp_run_last,
   // configuration
   input  logic                   csr_wr_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   typedef struct packed {
      logic [PIX_CH_W-1:0] blue;
      logic [PIX_CH_W-1:0] green;
      logic [PIX_CH_W-1:0] red;
   } pix_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_DRAIN,
      ST_KICK,
      ST_DIVIDE,
      ST_LOAD
   } state_type;

   // row slot helpers, slot is row mod 3
   function automatic logic [SLOT_W-1:0] slot_inc(input logic [SLOT_W-1:0] s);
      slot_inc = (s == 2'd2) ? 2'd0 : s + 2'd1;
   endfunction

   function automatic logic [SLOT_W-1:0] slot_back(input logic [SLOT_W-1:0] s,
                                                   input logic [1:0] d);
      logic [2:0] t;
      t = {1'b0, s} + 3'd3 - {1'b0, d};
      if (t >= 3'd3) begin
         t = t - 3'd3;
      end
      slot_back = t[SLOT_W-1:0];
   endfunction

   // pixels in a neighborhood of (d_hi+1) rows by (e_hi+1) columns
   function automatic logic [CNT_W-1:0] nb_count(input logic [1:0] dh, input logic [1:0] eh);
      logic [CNT_W-1:0] c;
      case ({dh, eh})
         4'b0000: c = 4'd1;
         4'b0001, 4'b0100: c = 4'd2;
         4'b0010, 4'b1000: c = 4'd3;
         4'b0101: c = 4'd4;
         4'b0110, 4'b1001: c = 4'd6;
         4'b1010: c = 4'd9;
         default: c = 4'd1;
      endcase
      nb_count = c;
   endfunction

   // configuration registers
   logic [FW_W-1:0]   fw_ff;
   logic [FH_W-1:0]   fh_ff;

   // frame position of the next pixel
   logic [ROW_W-1:0]  row_cnt_ff;
   logic [COL_W-1:0]  col_cnt_ff;
   logic [SLOT_W-1:0] row_slot_ff;

   // sequencer state
   state_type         state_ff;
   logic [ROW_W-1:0]  pix_row_ff;
   logic [COL_W-1:0]  pix_col_ff;
   logic [SLOT_W-1:0] pix_slot_ff;
   logic              o_dr_ff;
   logic              o_dc_ff;
   logic              row_two_ff;
   logic              col_two_ff;
   logic              col_first_ff;
   logic [1:0]        nb_d_ff;
   logic [1:0]        nb_e_ff;
   logic              rd_valid_ff;
   logic [SUM_W-1:0]  sum_r_ff;
   logic [SUM_W-1:0]  sum_g_ff;
   logic [SUM_W-1:0]  sum_b_ff;

   // output register
   logic              rsp_valid_ff;
   logic [ROW_W-1:0]  rsp_row_ff;
   logic [COL_W-1:0]  rsp_col_ff;
   logic [PIX_CH_W-1:0] rsp_red_ff;
   logic [PIX_CH_W-1:0] rsp_green_ff;
   logic [PIX_CH_W-1:0] rsp_blue_ff;
   logic              rsp_last_ff;

   // line store
   pix_type           line_store [STORE_DEPTH];
   pix_type           rd_data_ff;

   // effective frame size
   logic [FW_W-1:0]   w_eff;
   logic [FH_W-1:0]   h_eff;
   logic [COL_W-1:0]  w_last;
   logic [ROW_W-1:0]  h_last;

   // position of the arriving pixel and the next one
   logic              wrap_col;
   logic [FH_W-1:0]   row_tmp;
   logic [SLOT_W-1:0] slot_tmp;
   logic [ROW_W-1:0]  cur_row;
   logic [COL_W-1:0]  cur_col;
   logic [SLOT_W-1:0] cur_slot;
   logic [FW_W-1:0]   col_step;
   logic [FH_W-1:0]   row_step;
   logic [ROW_W-1:0]  row_cnt_in;
   logic [COL_W-1:0]  col_cnt_in;
   logic [SLOT_W-1:0] row_slot_in;
   logic              has_up;
   logic              has_cur_row;
   logic              has_left;
   logic              has_cur_col;
   logic              req_accept;
   pix_type           req_pix;
   logic [ADDR_W-1:0] wr_addr;

   // neighborhood walk
   logic [ROW_W-1:0]  oi;
   logic [COL_W-1:0]  oj;
   logic [1:0]        d_hi;
   logic [1:0]        e_hi;
   logic [CNT_W-1:0]  count;
   logic              last_issue;
   logic              is_last;
   logic              rd_en;
   logic [ADDR_W-1:0] rd_addr;
   logic [COL_W-1:0]  rd_col;
   logic              rsp_free;

   // divider hookup
   logic                 div_start;
   logic [DIV_DEN_W-1:0] div_den;
   logic [DIV_NUM_W-1:0] num_r;
   logic [DIV_NUM_W-1:0] num_g;
   logic [DIV_NUM_W-1:0] num_b;
   logic                 done_r;
   logic                 done_g;
   logic                 done_b;
   logic                 div_done;
   logic [PIX_CH_W-1:0]  q_r;
   logic [PIX_CH_W-1:0]  q_g;
   logic [PIX_CH_W-1:0]  q_b;

   // clamp the configured size to 1..max
   always_comb begin
      if (fw_ff == '0) begin
         w_eff = FW_W'(1);
      end else if (fw_ff > FW_W'(MAX_WIDTH)) begin
         w_eff = FW_W'(MAX_WIDTH);
      end else begin
         w_eff = fw_ff;
      end
      if (fh_ff == '0) begin
         h_eff = FH_W'(1);
      end else if (fh_ff > FH_W'(MAX_HEIGHT)) begin
         h_eff = FH_W'(MAX_HEIGHT);
      end else begin
         h_eff = fh_ff;
      end
   end

   assign w_last = COL_W'(w_eff - FW_W'(1));
   assign h_last = ROW_W'(h_eff - FH_W'(1));

   // position of this pixel: wrap counters left beyond the frame
   always_comb begin
      wrap_col = {1'b0, col_cnt_ff} >= w_eff;
      row_tmp  = wrap_col ? ({1'b0, row_cnt_ff} + FH_W'(1)) : {1'b0, row_cnt_ff};
      slot_tmp = wrap_col ? slot_inc(row_slot_ff) : row_slot_ff;
      cur_col  = wrap_col ? '0 : col_cnt_ff;
      if (row_tmp >= h_eff) begin
         cur_row  = '0;
         cur_slot = '0;
      end else begin
         cur_row  = row_tmp[ROW_W-1:0];
         cur_slot = slot_tmp;
      end
   end

   // position of the next pixel
   always_comb begin
      col_step    = {1'b0, cur_col} + FW_W'(1);
      row_step    = {1'b0, cur_row} + FH_W'(1);
      row_cnt_in  = cur_row;
      col_cnt_in  = col_step[COL_W-1:0];
      row_slot_in = cur_slot;
      if (col_step >= w_eff) begin
         col_cnt_in = '0;
         if (row_step >= h_eff) begin
            row_cnt_in  = '0;
            row_slot_in = '0;
         end else begin
            row_cnt_in  = row_step[ROW_W-1:0];
            row_slot_in = slot_inc(cur_slot);
         end
      end
   end

   // which outputs this pixel completes
   assign has_up      = cur_row != '0;
   assign has_cur_row = cur_row == h_last;
   assign has_left    = cur_col != '0;
   assign has_cur_col = cur_col == w_last;

   assign req_ready  = state_ff == ST_IDLE;
   assign req_accept = req_valid && req_ready;
   assign req_pix    = '{blue: req_blue_in, green: req_green_in, red: req_red_in};
   assign wr_addr    = {cur_slot, cur_col};

   // current output and its neighborhood bounds
   always_comb begin
      oi         = pix_row_ff - ROW_W'(o_dr_ff);
      oj         = pix_col_ff - COL_W'(o_dc_ff);
      d_hi       = {1'b0, o_dr_ff} + {1'b0, oi != '0};
      e_hi       = {1'b0, o_dc_ff} + {1'b0, oj != '0};
      count      = nb_count(d_hi, e_hi);
      last_issue = (nb_d_ff == d_hi) && (nb_e_ff == e_hi);
      is_last    = !(o_dc_ff && col_two_ff) && !(o_dr_ff && row_two_ff);
      rd_en      = state_ff == ST_READ;
      rd_col     = pix_col_ff - COL_W'(nb_e_ff);
      rd_addr    = {slot_back(pix_slot_ff, nb_d_ff), rd_col};
      rsp_free   = !rsp_valid_ff || rsp_ready;
   end

   // line store: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (req_accept) begin
         line_store[wr_addr] <= req_pix;
      end
      if (rd_en) begin
         rd_data_ff <= line_store[rd_addr];
      end
   end

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         fw_ff <= FW_RESET;
         fh_ff <= FH_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_FRAME_WIDTH:  fw_ff <= csr_wdata[FW_W-1:0];
            CSR_FRAME_HEIGHT: fh_ff <= csr_wdata[FH_W-1:0];
            default: ;
         endcase
      end
   end

   // frame position counters
   always_ff @(posedge clock) begin
      if (reset) begin
         row_cnt_ff  <= '0;
         col_cnt_ff  <= '0;
         row_slot_ff <= '0;
      end else if (req_accept) begin
         row_cnt_ff  <= row_cnt_in;
         col_cnt_ff  <= col_cnt_in;
         row_slot_ff <= row_slot_in;
      end
   end

   // sequencer and output register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rd_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rd_valid_ff <= rd_en;
         if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (rd_valid_ff) begin
            sum_r_ff <= sum_r_ff + SUM_W'(rd_data_ff.red);
            sum_g_ff <= sum_g_ff + SUM_W'(rd_data_ff.green);
            sum_b_ff <= sum_b_ff + SUM_W'(rd_data_ff.blue);
         end
         case (state_ff)
            ST_IDLE: begin
               if (req_accept && (has_up || has_cur_row) && (has_left || has_cur_col)) begin
                  pix_row_ff   <= cur_row;
                  pix_col_ff   <= cur_col;
                  pix_slot_ff  <= cur_slot;
                  o_dr_ff      <= has_up;
                  o_dc_ff      <= has_left;
                  row_two_ff   <= has_up && has_cur_row;
                  col_two_ff   <= has_left && has_cur_col;
                  col_first_ff <= has_left;
                  nb_d_ff      <= '0;
                  nb_e_ff      <= '0;
                  sum_r_ff     <= '0;
                  sum_g_ff     <= '0;
                  sum_b_ff     <= '0;
                  state_ff     <= ST_READ;
               end
            end
            ST_READ: begin
               // walk columns inside rows, one read per cycle
               if (nb_e_ff == e_hi) begin
                  nb_e_ff <= '0;
                  nb_d_ff <= nb_d_ff + 2'd1;
               end else begin
                  nb_e_ff <= nb_e_ff + 2'd1;
               end
               if (last_issue) begin
                  state_ff <= ST_DRAIN;
               end
            end
            ST_DRAIN: begin
               state_ff <= ST_KICK;
            end
            ST_KICK: begin
               state_ff <= ST_DIVIDE;
            end
            ST_DIVIDE: begin
               if (div_done) begin
                  state_ff <= ST_LOAD;
               end
            end
            ST_LOAD: begin
               if (rsp_free) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_row_ff   <= oi;
                  rsp_col_ff   <= oj;
                  rsp_red_ff   <= q_r;
                  rsp_green_ff <= q_g;
                  rsp_blue_ff  <= q_b;
                  rsp_last_ff  <= is_last;
                  nb_d_ff      <= '0;
                  nb_e_ff      <= '0;
                  sum_r_ff     <= '0;
                  sum_g_ff     <= '0;
                  sum_b_ff     <= '0;
                  if (is_last) begin
                     state_ff <= ST_IDLE;
                  end else begin
                     state_ff <= ST_READ;
                     if (o_dc_ff && col_two_ff) begin
                        o_dc_ff <= 1'b0;
                     end else begin
                        o_dr_ff <= 1'b0;
                        o_dc_ff <= col_first_ff;
                     end
                  end
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   // rounded mean: (2*sum + count) / (2*count)
   assign div_start = state_ff == ST_KICK;
   assign div_den   = {1'b0, count};
   assign num_r     = {sum_r_ff, 1'b0} + DIV_NUM_W'(count);
   assign num_g     = {sum_g_ff, 1'b0} + DIV_NUM_W'(count);
   assign num_b     = {sum_b_ff, 1'b0} + DIV_NUM_W'(count);
   assign div_done  = done_r && done_g && done_b;

   bbe_div u_div_r (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (num_r),
      .den   (div_den << 1),
      .done  (done_r),
      .quot  (q_r)
   );

   bbe_div u_div_g (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (num_g),
      .den   (div_den << 1),
      .done  (done_g),
      .quot  (q_g)
   );

   bbe_div u_div_b (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (num_b),
      .den   (div_den << 1),
      .done  (done_b),
      .quot  (q_b)
   );

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_row   = rsp_row_ff;
   assign rsp_out_col   = rsp_col_ff;
   assign rsp_red_out   = rsp_red_ff;
   assign rsp_green_out = rsp_green_ff;
   assign rsp_blue_out  = rsp_blue_ff;
   assign rsp_run_last  = rsp_last_ff;

endmodule

FILE: tb/box_blur_3x3_edge_aware_test.sv
// box_blur_3x3_edge_aware_test: self-checking bench for the edge-aware 3x3 box blur
// drives pixel beats and csr writes, predicts every blurred pixel and checks each result beat
// depends on bbe_pkg and box_blur_3x3_edge_aware
module box_blur_3x3_edge_aware_test import bbe_pkg::*; ;
   timeunit 1ns;
   timeprecision 1ps;

   // cycles to let the pipeline settle once nothing more is expected
   localparam int DRAIN_CYCLES = 40;
   localparam int RANDOM_PIXELS = 300;

   typedef struct {
      logic [ROW_W-1:0]    row;
      logic [COL_W-1:0]    col;
      logic [PIX_CH_W-1:0] red;
      logic [PIX_CH_W-1:0] green;
      logic [PIX_CH_W-1:0] blue;
      logic                last;
   } blur_pixel_t;

   // blur predictor and store of pending blurred pixels
   class blur_scoreboard;
      logic [FW_W-1:0]         width_reg;
      logic [FH_W-1:0]         height_reg;
      int unsigned             row_pos;
      int unsigned             col_pos;
      logic [3*PIX_CH_W-1:0]   line_mem [STORE_DEPTH];
      blur_pixel_t             pending_q [$];
      int                      errors;

      function new();
         width_reg  = FW_RESET;
         height_reg = FH_RESET;
         row_pos    = 0;
         col_pos    = 0;
         errors     = 0;
         foreach (line_mem[k]) line_mem[k] = '0;
      endfunction

      function void write_reg(logic [CSR_INDEX_W-1:0] index, logic [CSR_DATA_W-1:0] value);
         if (index == CSR_FRAME_WIDTH) width_reg = value[FW_W-1:0];
         else height_reg = value[FH_W-1:0];
      endfunction

      // store the pixel and queue every blurred pixel whose window it completes
      function void note_pixel(logic [PIX_CH_W-1:0] red, logic [PIX_CH_W-1:0] green,
                               logic [PIX_CH_W-1:0] blue);
         int unsigned w, h, nr, nc, n, a, b, rr, cc, r0, r1, c0, c1, cnt;
         int unsigned rows [2];
         int unsigned cols [2];
         int unsigned sum [3];
         logic [3*PIX_CH_W-1:0] pix;
         blur_pixel_t px;
         w = (width_reg == 0) ? 1 : (width_reg > MAX_WIDTH) ? MAX_WIDTH : 32'(width_reg);
         h = (height_reg == 0) ? 1 : (height_reg > MAX_HEIGHT) ? MAX_HEIGHT : 32'(height_reg);
         // counters left beyond a shrunk frame wrap on arrival
         if (col_pos >= w) begin
            col_pos = 0;
            row_pos++;
         end
         if (row_pos >= h) row_pos = 0;
         line_mem[(row_pos % 3) * MAX_WIDTH + col_pos] = {blue, green, red};

         nr = 0;
         nc = 0;
         if (row_pos >= 1) begin
            rows[nr] = row_pos - 1;
            nr++;
         end
         if (row_pos == h - 1) begin
            rows[nr] = row_pos;
            nr++;
         end
         if (col_pos >= 1) begin
            cols[nc] = col_pos - 1;
            nc++;
         end
         if (col_pos == w - 1) begin
            cols[nc] = col_pos;
            nc++;
         end

         // rounded mean over the in-bounds window, row-then-column order
         n = 0;
         for (a = 0; a < nr; a++) begin
            for (b = 0; b < nc; b++) begin
               r0 = (rows[a] > 0) ? rows[a] - 1 : 0;
               r1 = (rows[a] + 1 < h) ? rows[a] + 1 : h - 1;
               c0 = (cols[b] > 0) ? cols[b] - 1 : 0;
               c1 = (cols[b] + 1 < w) ? cols[b] + 1 : w - 1;
               sum = '{0, 0, 0};
               cnt = 0;
               for (rr = r0; rr <= r1; rr++) begin
                  for (cc = c0; cc <= c1; cc++) begin
                     pix = line_mem[(rr % 3) * MAX_WIDTH + cc];
                     sum[0] += 32'(pix[7:0]);
                     sum[1] += 32'(pix[15:8]);
                     sum[2] += 32'(pix[23:16]);
                     cnt++;
                  end
               end
               px.row   = ROW_W'(rows[a]);
               px.col   = COL_W'(cols[b]);
               px.red   = PIX_CH_W'((2 * sum[0] + cnt) / (2 * cnt));
               px.green = PIX_CH_W'((2 * sum[1] + cnt) / (2 * cnt));
               px.blue  = PIX_CH_W'((2 * sum[2] + cnt) / (2 * cnt));
               px.last  = (n == nr * nc - 1);
               pending_q.push_back(px);
               n++;
            end
         end

         col_pos++;
         if (col_pos >= w) begin
            col_pos = 0;
            row_pos++;
            if (row_pos >= h) row_pos = 0;
         end
      endfunction

      task report(string msg);
         errors++;
         $display("[%0t] mismatch: %s", $time, msg);
      endtask

      // compare a result beat with the oldest pending blurred pixel
      task check_result(blur_pixel_t got);
         blur_pixel_t want;
         if (pending_q.size() == 0) begin
            report($sformatf("result beat (%0d,%0d) with nothing pending", got.row, got.col));
            return;
         end
         want = pending_q.pop_front();
         if (got.row !== want.row)
            report($sformatf("out_row got %0d want %0d", got.row, want.row));
         if (got.col !== want.col)
            report($sformatf("out_col got %0d want %0d", got.col, want.col));
         if (got.red !== want.red)
            report($sformatf("red_out at (%0d,%0d) got %0d want %0d",
                             want.row, want.col, got.red, want.red));
         if (got.green !== want.green)
            report($sformatf("green_out at (%0d,%0d) got %0d want %0d",
                             want.row, want.col, got.green, want.green));
         if (got.blue !== want.blue)
            report($sformatf("blue_out at (%0d,%0d) got %0d want %0d",
                             want.row, want.col, got.blue, want.blue));
         if (got.last !== want.last)
            report($sformatf("run_last at (%0d,%0d) got %0b want %0b",
                             want.row, want.col, got.last, want.last));
      endtask
   endclass

   logic                   clock;
   logic                   reset;
   logic                   req_valid;
   logic                   req_ready;
   logic [PIX_CH_W-1:0]    req_red_in;
   logic [PIX_CH_W-1:0]    req_green_in;
   logic [PIX_CH_W-1:0]    req_blue_in;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   logic [ROW_W-1:0]       rsp_out_row;
   logic [COL_W-1:0]       rsp_out_col;
   logic [PIX_CH_W-1:0]    rsp_red_out;
   logic [PIX_CH_W-1:0]    rsp_green_out;
   logic [PIX_CH_W-1:0]    rsp_blue_out;
   logic                   rsp_run_last;
   logic                   csr_wr_en;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   blur_scoreboard sb;
   int idle_pct = 31;

   box_blur_3x3_edge_aware u_dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_red_in    (req_red_in),
      .req_green_in  (req_green_in),
      .req_blue_in   (req_blue_in),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_out_row   (rsp_out_row),
      .rsp_out_col   (rsp_out_col),
      .rsp_red_out   (rsp_red_out),
      .rsp_green_out (rsp_green_out),
      .rsp_blue_out  (rsp_blue_out),
      .rsp_run_last  (rsp_run_last),
      .csr_wr_en     (csr_wr_en),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // random back-pressure on the result side
   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= idle_pct);
   end

   // result monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_ready)
         sb.check_result('{rsp_out_row, rsp_out_col, rsp_red_out, rsp_green_out,
                           rsp_blue_out, rsp_run_last});
   end

   // one pixel beat, with random idle cycles ahead of it
   task automatic send_pixel(logic [PIX_CH_W-1:0] red, logic [PIX_CH_W-1:0] green,
                             logic [PIX_CH_W-1:0] blue);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_red_in   <= red;
      req_green_in <= green;
      req_blue_in  <= blue;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sb.note_pixel(red, green, blue);
   endtask

   // random pixels, with flat black and flat white mixed in
   task automatic send_noise_pixels(int count);
      int mode;
      repeat (count) begin
         mode = $urandom_range(9);
         if (mode == 0) send_pixel(8'h00, 8'h00, 8'h00);
         else if (mode == 1) send_pixel(8'hFF, 8'hFF, 8'hFF);
         else send_pixel(8'($urandom), 8'($urandom), 8'($urandom));
      end
   endtask

   task automatic write_csr(logic [CSR_INDEX_W-1:0] index, logic [CSR_DATA_W-1:0] value);
      csr_wr_en <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      sb.write_reg(index, value);
      @(posedge clock);
   endtask

   task automatic set_frame(logic [CSR_DATA_W-1:0] width, logic [CSR_DATA_W-1:0] height);
      write_csr(CSR_FRAME_WIDTH, width);
      write_csr(CSR_FRAME_HEIGHT, height);
   endtask

   // block idle: nothing pending and pipeline settled
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (sb.pending_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   initial begin
      int k, w, h, pick, count, random_pixels;
      reset        = 1'b1;
      req_valid    = 1'b0;
      req_red_in   = '0;
      req_green_in = '0;
      req_blue_in  = '0;
      csr_wr_en    = 1'b0;
      csr_index    = CSR_FRAME_WIDTH;
      csr_wdata    = '0;
      sb = new();
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // size change mid-frame: width shrinks mid-row, then height below the current row
      set_frame(4, 6);
      for (k = 0; k < 10; k++) send_pixel({8{k[0]}}, {8{k[1]}}, {8{k[2]}});
      wait_idle();
      write_csr(CSR_FRAME_WIDTH, 2);
      send_pixel(8'hFF, 8'h00, 8'hFF);
      wait_idle();
      write_csr(CSR_FRAME_HEIGHT, 3);
      for (k = 0; k < 5; k++) send_pixel({8{k[1]}}, {8{k[0]}}, {8{~k[0]}});
      wait_idle();

      // zero sizes act as one: single column, single row, single pixel
      set_frame(0, 3);
      for (k = 0; k < 3; k++) send_pixel({8{k[0]}}, 8'hFF, 8'h00);
      wait_idle();
      set_frame(4, 0);
      for (k = 0; k < 4; k++) send_pixel(8'h00, {8{k[0]}}, 8'hFF);
      wait_idle();
      set_frame(0, 0);
      send_pixel(8'hFF, 8'h80, 8'h7F);
      wait_idle();

      // oversized registers clamp to the widest row and the tallest column
      set_frame(13'h07FF, 1);
      send_noise_pixels(MAX_WIDTH);
      wait_idle();
      idle_pct = 0;
      set_frame(1, 13'h1FFF);
      send_noise_pixels(MAX_HEIGHT);
      wait_idle();
      idle_pct = 31;

      // random whole frames, mostly small, upper width bits randomized
      random_pixels = 0;
      while (random_pixels < RANDOM_PIXELS) begin
         pick = $urandom_range(9);
         w = $urandom_range(1, 9);
         h = $urandom_range(1, 7);
         if (pick == 0) w = 0;
         else if (pick == 1) h = 0;
         else if (pick == 2) begin
            w = $urandom_range(10, 48);
            h = $urandom_range(1, 3);
         end
         count = ((w == 0) ? 1 : w) * ((h == 0) ? 1 : h) * $urandom_range(1, 2);
         idle_pct = (random_pixels >= 60 && random_pixels < 160) ? 0 : 31;
         wait_idle();
         set_frame({2'($urandom_range(3)), 11'(w)}, 13'(h));
         send_noise_pixels(count);
         random_pixels += count;
      end

      // final drain, bounded
      req_valid <= 1'b0;
      for (k = 0; k < 20000 && sb.pending_q.size() != 0; k++) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.pending_q.size() != 0)
         sb.report($sformatf("%0d blurred pixels never arrived", sb.pending_q.size()));
      if (sb.errors == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

   // watchdog, far beyond the slowest legal run
   initial begin
      #50_000_000;
      $display("TEST FAILED");
      $finish;
   end

endmodule

FILE: sim.f
sv/bbe_pkg.sv
sv/bbe_div.sv
sv/box_blur_3x3_edge_aware.sv
tb/box_blur_3x3_edge_aware_test.sv
